@@ src/tmec_pkg.sv @@
// ----------------------------------------------------------------------------
// tmec_pkg
// shared types, codes and fixed-point helpers of the master effort controller
// ----------------------------------------------------------------------------
package tmec_pkg;

    localparam logic signed [31:0] MAX32    = 32'sh7fffffff;
    localparam logic signed [31:0] MIN32    = 32'sh80000000;
    localparam logic signed [31:0] DEADBAND = 32'sd66;     // 0.001 in q16.16
    localparam logic signed [31:0] Q_ONE    = 32'sd65536;

    typedef enum logic [1:0] {
        MODE_FOUR    = 2'd0,
        MODE_WAVE    = 2'd1,
        MODE_PASSIVE = 2'd2,
        MODE_RESET   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_KP_MASTER   = 3'd0,
        REG_KV_MASTER   = 3'd1,
        REG_KP_COUPLING = 3'd2,
        REG_KV_COUPLING = 3'd3,
        REG_KF_COUPLING = 3'd4,
        REG_WAVE_ROOT   = 3'd5,
        REG_FILTER_TC   = 3'd6,
        REG_ALPHA_LIMIT = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_ACC, S_ALPHA, S_DIV, S_WRITE, S_OUT
    } t_state;

    // one entry per multiply of the step sequence
    typedef enum logic [4:0] {
        OP_CM0, OP_CM1, OP_C10, OP_C11, OP_C3,
        OP_B, OP_I0, OP_I1, OP_I2, OP_U0, OP_U1, OP_F,
        OP_P0, OP_P1, OP_P2, OP_P3, OP_A0, OP_A1, OP_EF
    } t_op;

    // per-axis state word held in the state memory
    typedef struct packed {
        logic signed [31:0] energy;
        logic signed [31:0] alpha;
        logic signed [31:0] vel;
        logic signed [31:0] filt;
    } t_axis_state;

    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [31:0] den;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return MAX32;
        end else if (v < -66'sd2147483648) begin
            return MIN32;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] x66(input logic signed [31:0] v);
        return 66'(v);
    endfunction

endpackage

@@ src/teleop_master_effort_controller.sv @@
// ----------------------------------------------------------------------------
// teleop_master_effort_controller
// one-axis master effort for four-channel teleoperation with wave and
// passivity modes
// ----------------------------------------------------------------------------
// One item is in work at a time. How long an item takes depends on its mode
// and is set by the single shared 33x33 multiplier and the bit-serial divider
// used for the filter gain and
// the damping gain. Per-axis state (energy, gain, velocity, filter value)
// sits in a small synchronous memory read at input transfer and written back
// once at the end of the item; valid bits cleared by reset make unwritten
// axes read as zero. A finished result waits in the output register while
// the next input transfer is taken. Gains are written over the apb-style
// port at byte address 4*i and read back there.
// ----------------------------------------------------------------------------
module teleop_master_effort_controller import tmec_pkg::*; #(
    parameter int AXES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_axis,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_velocity,
    input  logic signed [31:0] i_force_req,
    input  logic signed [31:0] i_slave_c2,
    input  logic signed [31:0] i_slave_c4,
    input  logic signed [31:0] i_slave_wave,
    input  logic [30:0]        i_period,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_out_axis,
    output logic signed [31:0] o_effort,
    output logic signed [31:0] o_local_term,
    output logic signed [31:0] o_coupling_c1,
    output logic signed [31:0] o_coupling_c3,
    output logic signed [31:0] o_filtered_wave,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    // configuration registers
    logic signed [31:0] r_kp_m, r_kv_m, r_kp_c, r_kv_c, r_kf_c;
    logic [30:0]        r_wroot, r_tc, r_alim;
    t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_m  <= '0;
            r_kv_m  <= '0;
            r_kp_c  <= '0;
            r_kv_c  <= '0;
            r_kf_c  <= '0;
            r_wroot <= 31'd65536;
            r_tc    <= '0;
            r_alim  <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_KP_MASTER:   r_kp_m  <= pwdata;
                REG_KV_MASTER:   r_kv_m  <= pwdata;
                REG_KP_COUPLING: r_kp_c  <= pwdata;
                REG_KV_COUPLING: r_kv_c  <= pwdata;
                REG_KF_COUPLING: r_kf_c  <= pwdata;
                REG_WAVE_ROOT:   r_wroot <= pwdata[30:0];
                REG_FILTER_TC:   r_tc    <= pwdata[30:0];
                REG_ALPHA_LIMIT: r_alim  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KP_MASTER:   prdata = r_kp_m;
            REG_KV_MASTER:   prdata = r_kv_m;
            REG_KP_COUPLING: prdata = r_kp_c;
            REG_KV_COUPLING: prdata = r_kv_c;
            REG_KF_COUPLING: prdata = r_kf_c;
            REG_WAVE_ROOT:   prdata = {1'b0, r_wroot};
            REG_FILTER_TC:   prdata = {1'b0, r_tc};
            REG_ALPHA_LIMIT: prdata = {1'b0, r_alim};
            default:         prdata = '0;
        endcase
    end

    // fsm and datapath registers
    t_state   r_state, n_state;
    t_op      r_op, n_op;
    logic [1:0]         r_axis;
    t_mode              r_mode;
    logic               r_inrange;
    logic signed [31:0] r_pos, r_vel, r_force, r_c2, r_c4, r_vsw;
    logic [30:0]        r_h;
    logic signed [31:0] r_e, n_e, r_a, n_a, r_vp, n_vp, r_filt, n_filt;
    logic signed [31:0] r_cm, n_cm, r_c1, n_c1, r_c3, n_c3, r_b, n_b;
    logic signed [31:0] r_t, n_t, r_um, n_um, r_alpha, n_alpha, r_eff, n_eff;
    logic signed [65:0] r_acc, n_acc, r_prod;
    logic signed [32:0] mul_a, mul_b;

    // state memory with reset-cleared valid bits
    t_axis_state        r_mem [AXES];
    logic [AXES-1:0]    r_vld;
    t_axis_state        r_rd;
    logic               r_rd_ok;
    t_axis_state        wdata;
    logic               mem_we;
    logic               in_acc, in_rng;
    logic [AW-1:0]      rd_idx, wr_idx;

    // divider
    t_div_req           div_req;
    logic               div_done;
    logic [47:0]        div_quo;

    // combinational helpers
    logic signed [31:0] q, fcm, af, ival;
    logic signed [65:0] neg_e;
    logic [31:0]        k_den;

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign in_rng  = (32'(i_axis) < AXES);
    assign rd_idx  = AW'(i_axis);
    assign wr_idx  = AW'(r_axis);
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= wdata;
        end
        if (in_acc && in_rng) begin
            r_rd <= r_mem[rd_idx];
        end
        if (in_acc) begin
            r_rd_ok <= in_rng && r_vld[rd_idx];
        end
    end

    // input capture at transfer
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_axis    <= i_axis;
            r_mode    <= t_mode'(i_mode);
            r_inrange <= in_rng;
            r_pos     <= i_position;
            r_vel     <= i_velocity;
            r_force   <= i_force_req;
            r_c2      <= i_slave_c2;
            r_c4      <= i_slave_c4;
            r_vsw     <= i_slave_wave;
            r_h       <= i_period;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_op)
            OP_CM0:  begin mul_a = {r_kp_m[31], r_kp_m}; mul_b = {r_pos[31], r_pos}; end
            OP_CM1:  begin mul_a = {r_kv_m[31], r_kv_m}; mul_b = {r_vel[31], r_vel}; end
            OP_C10:  begin mul_a = {r_kp_c[31], r_kp_c}; mul_b = {r_pos[31], r_pos}; end
            OP_C11:  begin mul_a = {r_kv_c[31], r_kv_c}; mul_b = {r_vel[31], r_vel}; end
            OP_C3:   begin mul_a = {r_kf_c[31], r_kf_c}; mul_b = {r_force[31], r_force}; end
            OP_B:    begin mul_a = {2'b0, r_wroot}; mul_b = {2'b0, r_wroot}; end
            OP_I0:   begin mul_a = {r_b[31], r_b}; mul_b = {r_c1[31], r_c1}; end
            OP_I1:   begin mul_a = {r_b[31], r_b}; mul_b = {r_c3[31], r_c3}; end
            OP_I2:   begin mul_a = {2'b0, r_wroot}; mul_b = {r_vsw[31], r_vsw}; end
            OP_U0:   begin mul_a = {2'b0, r_wroot}; mul_b = {r_c1[31], r_c1}; end
            OP_U1:   begin mul_a = {2'b0, r_wroot}; mul_b = {r_c3[31], r_c3}; end
            OP_F:    begin
                mul_a = {r_t[31], r_t};
                mul_b = {r_um[31], r_um} - {r_filt[31], r_filt};
            end
            OP_P0:   begin mul_a = {fcm[31], fcm}; mul_b = {r_vel[31], r_vel}; end
            OP_P1:   begin mul_a = {r_vp[31], r_vp}; mul_b = {r_vp[31], r_vp}; end
            OP_P2:   begin mul_a = {r_a[31], r_a}; mul_b = {r_t[31], r_t}; end
            OP_P3:   begin mul_a = {2'b0, r_h}; mul_b = {r_t[31], r_t}; end
            OP_A0:   begin mul_a = {r_vel[31], r_vel}; mul_b = {r_vel[31], r_vel}; end
            OP_A1:   begin mul_a = {2'b0, r_h}; mul_b = {r_t[31], r_t}; end
            OP_EF:   begin mul_a = {af[31], af}; mul_b = {r_vel[31], r_vel}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // q16.16 product, floor then saturate
    assign q     = sat32(r_prod >>> 16);
    assign fcm   = sat32(-x66(r_c2) - x66(r_c4));
    assign af    = (r_alpha > $signed({1'b0, r_alim})) ? $signed({1'b0, r_alim}) : r_alpha;
    assign ival  = sat32(r_acc + x66(q));
    assign neg_e = -x66(r_e);
    assign k_den = {1'b0, r_tc} + {1'b0, r_h};

    // next state and datapath sequencing
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_e     = r_e;
        n_a     = r_a;
        n_vp    = r_vp;
        n_filt  = r_filt;
        n_cm    = r_cm;
        n_c1    = r_c1;
        n_c3    = r_c3;
        n_b     = r_b;
        n_t     = r_t;
        n_um    = r_um;
        n_alpha = r_alpha;
        n_eff   = r_eff;
        n_acc   = r_acc;
        div_req = '0;
        mem_we  = 1'b0;
        wdata   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_e     = r_rd_ok ? r_rd.energy : '0;
                n_a     = r_rd_ok ? r_rd.alpha  : '0;
                n_vp    = r_rd_ok ? r_rd.vel    : '0;
                n_filt  = r_rd_ok ? r_rd.filt   : '0;
                n_alpha = '0;
                n_op    = OP_CM0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_MUL;
                case (r_op)
                    OP_CM0: begin n_acc = x66(q); n_op = OP_CM1; end
                    OP_CM1: begin n_cm = sat32(r_acc + x66(q)); n_op = OP_C10; end
                    OP_C10: begin n_acc = x66(q); n_op = OP_C11; end
                    OP_C11: begin n_c1 = sat32(r_acc + x66(q)); n_op = OP_C3; end
                    OP_C3: begin
                        n_c3 = q;
                        case (r_mode)
                            MODE_FOUR: begin
                                n_eff   = sat32(-x66(r_cm) + x66(r_c2) + x66(r_c4));
                                n_state = S_WRITE;
                            end
                            MODE_WAVE: begin
                                n_op = OP_B;
                            end
                            MODE_PASSIVE: begin
                                if (r_e > 32'sd0) begin
                                    n_e     = '0;
                                    n_state = S_ALPHA;
                                end else begin
                                    n_op = OP_P0;
                                end
                            end
                            default: begin
                                // reset mode clears couplings, effort and state
                                n_c1    = '0;
                                n_c3    = '0;
                                n_eff   = '0;
                                n_filt  = '0;
                                n_e     = '0;
                                n_a     = '0;
                                n_state = S_WRITE;
                            end
                        endcase
                    end
                    // impedance is the root squared and halved
                    OP_B:  begin n_b = sat32(r_prod >>> 17); n_op = OP_I0; end
                    OP_I0: begin n_acc = x66(q); n_op = OP_I1; end
                    OP_I1: begin n_acc = r_acc + x66(q); n_op = OP_I2; end
                    OP_I2: begin
                        n_eff = sat32(-x66(r_cm) - x66(ival));
                        n_op  = OP_U0;
                    end
                    OP_U0: begin n_acc = x66(r_vsw) + x66(q); n_op = OP_U1; end
                    OP_U1: begin
                        n_um = sat32(r_acc + x66(q));
                        n_op = OP_F;
                        if (k_den == '0) begin
                            n_t = Q_ONE;
                        end else begin
                            div_req.start = 1'b1;
                            div_req.num   = {1'b0, r_h, 16'b0};
                            div_req.den   = k_den;
                            n_state       = S_DIV;
                        end
                    end
                    OP_F: begin
                        n_filt  = sat32(x66(r_filt) + x66(q));
                        n_state = S_WRITE;
                    end
                    OP_P0: begin n_acc = x66(q); n_op = OP_P1; end
                    OP_P1: begin n_t = q; n_op = OP_P2; end
                    OP_P2: begin n_t = sat32(r_acc + x66(q)); n_op = OP_P3; end
                    OP_P3: begin
                        n_e     = sat32(x66(r_e) + x66(q));
                        n_state = S_ALPHA;
                    end
                    OP_A0: begin n_t = q; n_op = OP_A1; end
                    OP_A1: begin
                        n_op = OP_EF;
                        if (q <= 32'sd0) begin
                            n_alpha = MAX32;
                        end else begin
                            div_req.start = 1'b1;
                            div_req.num   = {neg_e[31:0], 16'b0};
                            div_req.den   = q;
                            n_state       = S_DIV;
                        end
                    end
                    OP_EF: begin
                        n_eff   = sat32(-x66(r_cm) - x66(q) + x66(r_c2) + x66(r_c4));
                        n_a     = r_alpha;
                        n_state = S_WRITE;
                    end
                    default: n_state = S_WRITE;
                endcase
            end
            S_ALPHA: begin
                n_state = S_MUL;
                if (r_e < 32'sd0 && (r_vel < -DEADBAND || r_vel > DEADBAND)) begin
                    n_op = OP_A0;
                end else begin
                    n_alpha = '0;
                    n_op    = OP_EF;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                    if (r_mode == MODE_WAVE) begin
                        n_t = div_quo[31:0];
                    end else begin
                        n_alpha = (div_quo[47:31] != '0) ? MAX32
                                                         : $signed({1'b0, div_quo[30:0]});
                    end
                end
            end
            S_WRITE: begin
                mem_we       = r_inrange;
                wdata.energy = r_e;
                wdata.alpha  = r_a;
                wdata.vel    = (r_mode == MODE_RESET) ? 32'sd0 : r_vel;
                wdata.filt   = r_filt;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CM0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_a     <= n_a;
        r_vp    <= n_vp;
        r_filt  <= n_filt;
        r_cm    <= n_cm;
        r_c1    <= n_c1;
        r_c3    <= n_c3;
        r_b     <= n_b;
        r_t     <= n_t;
        r_um    <= n_um;
        r_alpha <= n_alpha;
        r_eff   <= n_eff;
        r_acc   <= n_acc;
    end

    tmec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // output register, freed by a result transfer
    logic r_out_valid;
    logic out_load;

    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_axis      <= r_axis;
            o_effort        <= r_eff;
            o_local_term    <= r_cm;
            o_coupling_c1   <= r_c1;
            o_coupling_c3   <= r_c3;
            o_filtered_wave <= r_filt;
        end
    end

    // divider only reports back while the sequencer waits on it
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // reset mode produces zero effort and couplings
    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_mode == MODE_RESET) |->
            (r_eff == '0 && r_c1 == '0 && r_c3 == '0 && r_filt == '0))
        else $error("reset mode result not cleared");

    // state memory written only once per item, right before the result is offered
    a_write_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_state == S_OUT))
        else $error("state write not followed by result stage");

endmodule

@@ src/tmec_div.sv @@
// ----------------------------------------------------------------------------
// tmec_div
// unsigned restoring divider, 48-bit dividend by 32-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module tmec_div import tmec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [47:0] o_quo
);

    logic [47:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh = {r_rem[31:0], r_q[47]};
    assign take   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= take ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_q   <= {r_q[46:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
